// ===== rtl/i2cmbe_pkg.sv =====
`default_nettype none

package i2cmbe_pkg;

  // Parameter defaults and register layout
  localparam int WAIT_W_DEFAULT = 16;
  localparam int TICKS_W = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd2500;

  // Register index (paddr[2])
  localparam logic REG_PHASE_TICKS = 1'b0;

  // Command codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] action;
    logic [7:0] write_data;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_data;
    logic       timed_out;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/i2cmbe_step.sv =====
`default_nettype none

module i2cmbe_step #(
  parameter int WAIT_WIDTH = i2cmbe_pkg::WAIT_W_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               step_en,
  input  wire i2cmbe_pkg::in_item_t         item,
  input  wire [i2cmbe_pkg::TICKS_W-1:0]     phase_ticks,
  output i2cmbe_pkg::out_item_t             res
);
  import i2cmbe_pkg::*;

  typedef enum logic [18:0] {
    PH_IDLE   = 19'h00001,
    PH_S_SDA  = 19'h00002,
    PH_S_SCL  = 19'h00004,
    PH_P_SDA  = 19'h00008,
    PH_P_SCL  = 19'h00010,
    PH_P_REL  = 19'h00020,
    PH_W_DAT  = 19'h00040,
    PH_W_HI   = 19'h00080,
    PH_W_LO   = 19'h00100,
    PH_W_AREL = 19'h00200,
    PH_W_AHI  = 19'h00400,
    PH_W_ALO  = 19'h00800,
    PH_R_REL  = 19'h01000,
    PH_R_HI   = 19'h02000,
    PH_R_LO   = 19'h04000,
    PH_R_ADRV = 19'h08000,
    PH_R_AHI  = 19'h10000,
    PH_R_ALO  = 19'h20000,
    PH_R_END  = 19'h40000
  } phase_t;

  phase_t                  phase_r, phase_nxt, tgt;
  logic [3:0]              bits_r, bits_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic                    ack_send_r, ack_send_nxt;
  logic [WAIT_WIDTH-1:0]   wait_r, wait_nxt;
  logic                    scl_r, scl_nxt;
  logic                    sda_r, sda_nxt;
  logic                    ack_seen_r, ack_seen_nxt;
  logic [7:0]              rdata_r, rdata_nxt;
  logic                    tmo_r, tmo_nxt;
  logic                    enter_en, finish, expired, checked;

  logic [WAIT_WIDTH+TICKS_W-1:0] ticks_ext;
  logic [WAIT_WIDTH-1:0]         ld_raw, wait_load;

  // Zero ticks is loaded as a wait of 1, the same as a setting of one tick
  assign ticks_ext = {{WAIT_WIDTH{1'b0}}, phase_ticks};
  assign ld_raw    = ticks_ext[WAIT_WIDTH-1:0];
  assign wait_load = (ld_raw == '0) ? WAIT_WIDTH'(1) : ld_raw;

  assign expired = (wait_r <= WAIT_WIDTH'(1));
  assign checked = (phase_r == PH_P_SCL) || (phase_r == PH_W_HI) ||
                   (phase_r == PH_W_AHI) || (phase_r == PH_R_HI) ||
                   (phase_r == PH_R_AHI);

  always_comb begin
    phase_nxt    = phase_r;
    bits_nxt     = bits_r;
    shift_nxt    = shift_r;
    ack_send_nxt = ack_send_r;
    wait_nxt     = wait_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ack_seen_nxt = ack_seen_r;
    rdata_nxt    = rdata_r;
    tmo_nxt      = tmo_r;
    tgt          = PH_IDLE;
    enter_en     = 1'b0;
    finish       = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid) begin
        ack_seen_nxt = 1'b0;
        tmo_nxt      = 1'b0;
        bits_nxt     = 4'd8;
        ack_send_nxt = item.send_ack;
        shift_nxt    = (item.action == ACT_WRITE) ? item.write_data : 8'h00;
        enter_en     = 1'b1;
        case (item.action)
          ACT_START: tgt = PH_S_SDA;
          ACT_STOP:  tgt = PH_P_SDA;
          ACT_WRITE: tgt = PH_W_DAT;
          default:   tgt = PH_R_REL;
        endcase
      end
    end else begin
      wait_nxt = wait_r - WAIT_WIDTH'(wait_r != '0);
      if (expired) begin
        if (checked && !item.scl_in) begin
          // slave stretching past the wait: abort, let SDA go
          sda_nxt = 1'b0;
          tmo_nxt = 1'b1;
          finish  = 1'b1;
        end else begin
          enter_en = 1'b1;
          case (phase_r)
            PH_S_SDA:  tgt = PH_S_SCL;
            PH_P_SDA:  tgt = PH_P_SCL;
            PH_P_SCL:  tgt = PH_P_REL;
            PH_W_DAT:  tgt = PH_W_HI;
            PH_W_HI:   tgt = PH_W_LO;
            PH_W_LO: begin
              shift_nxt = {shift_r[6:0], 1'b0};
              bits_nxt  = bits_r - 4'd1;
              tgt       = (bits_nxt == 4'd0) ? PH_W_AREL : PH_W_DAT;
            end
            PH_W_AREL: tgt = PH_W_AHI;
            PH_W_AHI: begin
              ack_seen_nxt = ~item.sda_in;
              tgt          = PH_W_ALO;
            end
            PH_R_REL:  tgt = PH_R_HI;
            PH_R_HI: begin
              shift_nxt = {shift_r[6:0], item.sda_in};
              tgt       = PH_R_LO;
            end
            PH_R_LO: begin
              bits_nxt = bits_r - 4'd1;
              tgt      = (bits_nxt == 4'd0) ? PH_R_ADRV : PH_R_HI;
            end
            PH_R_ADRV: tgt = PH_R_AHI;
            PH_R_AHI:  tgt = PH_R_ALO;
            PH_R_ALO:  tgt = PH_R_END;
            PH_R_END: begin
              rdata_nxt = shift_r;
              enter_en  = 1'b0;
              finish    = 1'b1;
            end
            default: begin
              enter_en = 1'b0;
              finish   = 1'b1;
            end
          endcase
        end
      end
    end

    // Pin change that opens the new phase, then restart the wait
    if (enter_en) begin
      phase_nxt = tgt;
      wait_nxt  = wait_load;
      case (tgt)
        PH_S_SDA, PH_P_SDA:                         sda_nxt = 1'b1;
        PH_S_SCL, PH_W_LO, PH_W_ALO, PH_R_LO, PH_R_ALO: scl_nxt = 1'b1;
        PH_P_SCL, PH_W_HI, PH_W_AHI, PH_R_HI, PH_R_AHI: scl_nxt = 1'b0;
        PH_P_REL, PH_W_AREL, PH_R_REL, PH_R_END:    sda_nxt = 1'b0;
        PH_W_DAT:                                   sda_nxt = ~shift_nxt[7];
        PH_R_ADRV:                                  sda_nxt = ack_send_nxt;
        default:                                    ;
      endcase
    end

    if (finish) begin
      phase_nxt = PH_IDLE;
      wait_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bits_r     <= '0;
      shift_r    <= '0;
      ack_send_r <= 1'b0;
      wait_r     <= '0;
      scl_r      <= 1'b0;
      sda_r      <= 1'b0;
      ack_seen_r <= 1'b0;
      rdata_r    <= '0;
      tmo_r      <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bits_r     <= bits_nxt;
      shift_r    <= shift_nxt;
      ack_send_r <= ack_send_nxt;
      wait_r     <= wait_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_seen_r <= ack_seen_nxt;
      rdata_r    <= rdata_nxt;
      tmo_r      <= tmo_nxt;
    end
  end

  always_comb begin
    res.scl_low   = scl_nxt;
    res.sda_low   = sda_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = finish;
    res.ack_seen  = ack_seen_nxt;
    res.read_data = rdata_nxt;
    res.timed_out = tmo_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine.sv =====
// The result for a transfer is registered and sits in the output register in the cycle after it is taken.
// One transfer per cycle while in_stall is low; each transfer is one step of the bus engine.
// Input is stalled only while a result sits in the output register and out_stall is high.
// Reset (rst_n low, synchronous) idles the engine, releases SCL/SDA, clears held
// status, empties the output register and sets phase_ticks to 2500.
`default_nettype none

module i2c_master_byte_engine #(
  parameter int WAIT_WIDTH = i2cmbe_pkg::WAIT_W_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // command / pin-sample transfers
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire i2cmbe_pkg::in_item_t          in_data,
  // result transfers
  output logic                               out_valid,
  input  wire                                out_stall,
  output i2cmbe_pkg::out_item_t              out_data,
  // APB-style register port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [i2cmbe_pkg::PADDR_W-1:0]      paddr,
  input  wire [i2cmbe_pkg::PDATA_W-1:0]      pwdata,
  output logic [i2cmbe_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready
);
  import i2cmbe_pkg::*;

  logic               in_fire;
  logic               cfg_wr;
  logic [TICKS_W-1:0] ticks_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;
  out_item_t          step_res;

  // Output register parts the sides: a new transfer is taken whenever the
  // held result is empty or leaves in this same cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // Register write on the access phase; only index 0 exists
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_PHASE_TICKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
    end else if (cfg_wr) begin
      ticks_r <= pwdata[TICKS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PHASE_TICKS) begin
      prdata = {{(PDATA_W-TICKS_W){1'b0}}, ticks_r};
    end
  end

  // One engine step per accepted transfer; step_res is its next-state view
  i2cmbe_step #(
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_fire),
    .item        (in_data),
    .phase_ticks (ticks_r),
    .res         (step_res)
  );

  assign out_valid_nxt = in_fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
